>>> hw/rtl/lattice_constant_fold_alu_top_defines.svh
// Assertion macros used by the top-level RTL.
`ifndef LATTICE_CONSTANT_FOLD_ALU_TOP_DEFINES_SVH
`define LATTICE_CONSTANT_FOLD_ALU_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define LCFA_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("lcfa assertion failed");
`define LCFA_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("lcfa assertion failed");
`else
`define LCFA_ASSERT(lbl, clk, rst_n, prop)
`define LCFA_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

>>> hw/rtl/lcfa_pkg.sv
package lcfa_pkg;

	localparam int unsigned DivSteps = 64;

	localparam logic [4:0] OP_MOV  = 5'd0;
	localparam logic [4:0] OP_NEG  = 5'd1;
	localparam logic [4:0] OP_NOT  = 5'd2;
	localparam logic [4:0] OP_ADD  = 5'd3;
	localparam logic [4:0] OP_SUB  = 5'd4;
	localparam logic [4:0] OP_MUL  = 5'd5;
	localparam logic [4:0] OP_DIV  = 5'd6;
	localparam logic [4:0] OP_MOD  = 5'd7;
	localparam logic [4:0] OP_AND  = 5'd8;
	localparam logic [4:0] OP_OR   = 5'd9;
	localparam logic [4:0] OP_XOR  = 5'd10;
	localparam logic [4:0] OP_SHL  = 5'd11;
	localparam logic [4:0] OP_SHR  = 5'd12;
	localparam logic [4:0] OP_EQ   = 5'd13;
	localparam logic [4:0] OP_NE   = 5'd14;
	localparam logic [4:0] OP_LT   = 5'd15;
	localparam logic [4:0] OP_LE   = 5'd16;
	localparam logic [4:0] OP_GT   = 5'd17;
	localparam logic [4:0] OP_GE   = 5'd18;
	localparam logic [4:0] OP_MEET = 5'd19;

	localparam logic [1:0] KIND_UNKNOWN = 2'd0;
	localparam logic [1:0] KIND_CONST   = 2'd1;
	localparam logic [1:0] KIND_VARYING = 2'd2;
	localparam logic [1:0] KIND_BAD     = 2'd3;

	localparam logic [1:0] SIZE_1B = 2'd0;
	localparam logic [1:0] SIZE_2B = 2'd1;
	localparam logic [1:0] SIZE_4B = 2'd2;
	localparam logic [1:0] SIZE_8B = 2'd3;

	localparam logic [5:0] SHIFT_MASK_WIDE   = 6'd63;
	localparam logic [5:0] SHIFT_MASK_NARROW = 6'd31;
	localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;

	typedef struct packed {
		logic [4:0]         opcode;
		logic [1:0]         a_kind;
		logic signed [63:0] a_value;
		logic [1:0]         b_kind;
		logic signed [63:0] b_value;
		logic               operand_signed;
		logic [1:0]         dest_size;
		logic               dest_signed;
	} req_t;

	typedef struct packed {
		logic [1:0]         result_kind;
		logic signed [63:0] result_value;
	} rsp_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] raw;
		logic        is_div;
		logic        is_mod;
		logic        neg_q;
		logic        neg_r;
		logic        do_cut;
		logic [1:0]  dest_size;
		logic        dest_signed;
	} meta_t;

	typedef struct packed {
		meta_t       meta;
		logic [63:0] rem;
		logic [63:0] quo;
		logic [63:0] dvs;
	} cell_t;

	function automatic logic [63:0] cut_dest(logic [63:0] v, logic [1:0] size, logic sx);
		logic [63:0] r;
		r = v;
		unique case (size)
			SIZE_1B: r = {{56{sx & v[7]}}, v[7:0]};
			SIZE_2B: r = {{48{sx & v[15]}}, v[15:0]};
			SIZE_4B: r = {{32{sx & v[31]}}, v[31:0]};
			SIZE_8B: r = v;
		endcase
		return r;
	endfunction

endpackage

>>> hw/rtl/lcfa_prep.sv
// Operand decode, lattice rules, simple ops and split 64-bit multiply.
module lcfa_prep (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              valid,
	input  lcfa_pkg::req_t    req,
	output logic              valid_s2,
	output lcfa_pkg::cell_t   data_s2
);
	logic [1:0]  ak, bk;
	logic [63:0] a, b, ca, cb, ma, mb, shr_v;
	logic [5:0]  sh;
	logic        sgn, na, nb, bz, ovf;
	logic [63:0] pll;
	logic [31:0] plh, phl;
	lcfa_pkg::meta_t m;

	logic            valid_s1;
	lcfa_pkg::meta_t meta_s1;
	logic            is_mul_s1;
	logic [63:0]     pll_s1, quo_s1, dvs_s1;
	logic [31:0]     plh_s1, phl_s1;
	lcfa_pkg::meta_t meta_mul;

	assign ak  = (req.a_kind == lcfa_pkg::KIND_BAD) ? lcfa_pkg::KIND_VARYING : req.a_kind;
	assign bk  = (req.b_kind == lcfa_pkg::KIND_BAD) ? lcfa_pkg::KIND_VARYING : req.b_kind;
	assign a   = req.a_value;
	assign b   = req.b_value;
	assign sgn = req.operand_signed;
	assign sh  = b[5:0] & ((req.dest_size == lcfa_pkg::SIZE_8B) ?
		lcfa_pkg::SHIFT_MASK_WIDE : lcfa_pkg::SHIFT_MASK_NARROW);
	assign shr_v = (sgn && a[63]) ? ~((~a) >> sh) : (a >> sh);
	// bias both operands so an unsigned compare acts signed
	assign ca  = sgn ? (a ^ lcfa_pkg::SIGN_BIT) : a;
	assign cb  = sgn ? (b ^ lcfa_pkg::SIGN_BIT) : b;
	assign na  = sgn & a[63];
	assign nb  = sgn & b[63];
	assign ma  = na ? (64'd0 - a) : a;
	assign mb  = nb ? (64'd0 - b) : b;
	assign bz  = (b == 64'd0);
	assign ovf = sgn && (a == lcfa_pkg::SIGN_BIT) && (b == '1);
	assign pll = a[31:0] * b[31:0];
	// cross products only feed the upper half, so keep their low 32 bits
	assign plh = a[31:0] * b[63:32];
	assign phl = a[63:32] * b[31:0];

	always_comb begin
		m             = '0;
		m.kind        = lcfa_pkg::KIND_VARYING;
		m.do_cut      = 1'b1;
		m.dest_size   = req.dest_size;
		m.dest_signed = req.dest_signed;
		m.neg_q       = na ^ nb;
		m.neg_r       = na;
		m.is_mod      = (req.opcode == lcfa_pkg::OP_MOD);
		priority if (req.opcode <= lcfa_pkg::OP_NOT) begin
			m.kind = ak;
			unique case (req.opcode)
				lcfa_pkg::OP_MOV: m.raw = a;
				lcfa_pkg::OP_NEG: m.raw = 64'd0 - a;
				default:          m.raw = ~a;
			endcase
		end else if (req.opcode <= lcfa_pkg::OP_GE) begin
			if (ak == lcfa_pkg::KIND_VARYING || bk == lcfa_pkg::KIND_VARYING) begin
				m.kind = lcfa_pkg::KIND_VARYING;
			end else if (ak == lcfa_pkg::KIND_UNKNOWN || bk == lcfa_pkg::KIND_UNKNOWN) begin
				m.kind = lcfa_pkg::KIND_UNKNOWN;
			end else begin
				m.kind = lcfa_pkg::KIND_CONST;
				unique case (req.opcode)
					lcfa_pkg::OP_ADD: m.raw = a + b;
					lcfa_pkg::OP_SUB: m.raw = a - b;
					lcfa_pkg::OP_DIV, lcfa_pkg::OP_MOD: begin
						if (bz || ovf) m.kind = lcfa_pkg::KIND_VARYING;
						else m.is_div = 1'b1;
					end
					lcfa_pkg::OP_AND: m.raw = a & b;
					lcfa_pkg::OP_OR:  m.raw = a | b;
					lcfa_pkg::OP_XOR: m.raw = a ^ b;
					lcfa_pkg::OP_SHL: m.raw = a << sh;
					lcfa_pkg::OP_SHR: m.raw = shr_v;
					lcfa_pkg::OP_EQ:  m.raw = {63'd0, a == b};
					lcfa_pkg::OP_NE:  m.raw = {63'd0, a != b};
					lcfa_pkg::OP_LT:  m.raw = {63'd0, ca < cb};
					lcfa_pkg::OP_LE:  m.raw = {63'd0, ca <= cb};
					lcfa_pkg::OP_GT:  m.raw = {63'd0, ca > cb};
					lcfa_pkg::OP_GE:  m.raw = {63'd0, ca >= cb};
					default:          m.raw = '0;  // multiply, filled in next stage
				endcase
			end
		end else if (req.opcode == lcfa_pkg::OP_MEET) begin
			m.do_cut = 1'b0;
			if (ak == lcfa_pkg::KIND_UNKNOWN) begin
				m.kind = bk;
				m.raw  = b;
			end else if (bk == lcfa_pkg::KIND_UNKNOWN) begin
				m.kind = ak;
				m.raw  = a;
			end else if (ak == lcfa_pkg::KIND_CONST && bk == lcfa_pkg::KIND_CONST && a == b) begin
				m.kind = lcfa_pkg::KIND_CONST;
				m.raw  = a;
			end
		end else begin
			m.kind = lcfa_pkg::KIND_VARYING;
		end
	end

	// second stage: sum the partial products into the raw value
	always_comb begin
		meta_mul = meta_s1;
		if (is_mul_s1) meta_mul.raw = pll_s1 + {plh_s1 + phl_s1, 32'd0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s1   <= m;
			is_mul_s1 <= (req.opcode == lcfa_pkg::OP_MUL);
			pll_s1    <= pll;
			plh_s1    <= plh;
			phl_s1    <= phl;
			quo_s1    <= ma;
			dvs_s1    <= mb;

			data_s2.meta <= meta_mul;
			data_s2.rem  <= '0;
			data_s2.quo  <= quo_s1;
			data_s2.dvs  <= dvs_s1;
		end
	end
endmodule

>>> hw/rtl/lcfa_div_cell.sv
// One restoring-division step; the dividend shifts out while quotient bits shift in.
module lcfa_div_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            valid_in,
	input  lcfa_pkg::cell_t d_in,
	output logic            valid_out,
	output lcfa_pkg::cell_t d_out
);
	logic [64:0] trial, diff;
	logic        ge;
	lcfa_pkg::cell_t nxt;

	assign trial = {d_in.rem, d_in.quo[63]};
	assign diff  = trial - {1'b0, d_in.dvs};
	assign ge    = !diff[64];

	always_comb begin
		nxt     = d_in;
		nxt.rem = ge ? diff[63:0] : trial[63:0];
		nxt.quo = {d_in.quo[62:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_out <= 1'b0;
		else if (en) valid_out <= valid_in;
	end

	always_ff @(posedge clk) begin
		if (en) d_out <= nxt;
	end
endmodule

>>> hw/rtl/lattice_constant_fold_alu_top.sv
// Lattice constant-folding unit: folds one operation on two lattice-tagged
// 64-bit operands (unknown, constant, varying) into a lattice result. It takes
// one request per cycle unless stalled, and each request passes in order through
// two decode/multiply stages, a chain of 64 division cells (one quotient bit
// each, fixed by the 64-bit dividend) and the output register.
// Every request walks the full chain, so latency does not depend on opcode.
// The whole pipeline advances only while the output register is empty or
// being taken, so in_ready follows out_ready in the same cycle.
`include "lattice_constant_fold_alu_top_defines.svh"
module lattice_constant_fold_alu_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  lcfa_pkg::req_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output lcfa_pkg::rsp_t out_data
);
	// global advance: everything moves when the output slot can take a request
	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	lcfa_pkg::cell_t chain_d [0:lcfa_pkg::DivSteps];
	logic            chain_v [0:lcfa_pkg::DivSteps];

	lcfa_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid    (in_valid),
		.req      (in_data),
		.valid_s2 (chain_v[0]),
		.data_s2  (chain_d[0])
	);

	// division chain; non-divide requests ride along untouched in meta
	for (genvar i = 0; i < lcfa_pkg::DivSteps; i++) begin : g_cell
		lcfa_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.valid_in  (chain_v[i]),
			.d_in      (chain_d[i]),
			.valid_out (chain_v[i+1]),
			.d_out     (chain_d[i+1])
		);
	end

	// sign fixup of quotient/remainder, destination cut, zero for non-constants
	lcfa_pkg::meta_t fm;
	logic [63:0] q_fix, r_fix, raw_v, val;
	assign fm    = chain_d[lcfa_pkg::DivSteps].meta;
	assign q_fix = fm.neg_q ? (64'd0 - chain_d[lcfa_pkg::DivSteps].quo)
		: chain_d[lcfa_pkg::DivSteps].quo;
	assign r_fix = fm.neg_r ? (64'd0 - chain_d[lcfa_pkg::DivSteps].rem)
		: chain_d[lcfa_pkg::DivSteps].rem;
	assign raw_v = fm.is_div ? (fm.is_mod ? r_fix : q_fix) : fm.raw;

	always_comb begin
		val = fm.do_cut ? lcfa_pkg::cut_dest(raw_v, fm.dest_size, fm.dest_signed) : raw_v;
		if (fm.kind != lcfa_pkg::KIND_CONST) val = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= chain_v[lcfa_pkg::DivSteps];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data.result_kind  <= fm.kind;
			out_data.result_value <= val;
		end
	end

	`LCFA_ASSERT(a_kind_legal, clk, arst_n, !out_valid || out_data.result_kind != lcfa_pkg::KIND_BAD)
	`LCFA_ASSERT(a_nonconst_zero, clk, arst_n, !out_valid || out_data.result_kind == lcfa_pkg::KIND_CONST || out_data.result_value == 64'sd0)
	`LCFA_ASSERT_NEXT(a_take_enters, clk, arst_n, in_valid && in_ready, u_prep.valid_s1)
	`LCFA_ASSERT_NEXT(a_stall_holds, clk, arst_n, !en, $stable(chain_v[lcfa_pkg::DivSteps]))
endmodule

>>> test/tb_lattice_constant_fold_alu_top.sv
`timescale 1ns / 100ps
module tb_lattice_constant_fold_alu_top;
	import lcfa_pkg::*;

	// Results come back in order.
	localparam int unsigned Latency = 67;
	localparam int unsigned IdleLimit = 2000;
	localparam int unsigned RandomReqs = 800;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	req_t in_data;
	logic out_valid;
	logic out_ready;
	rsp_t out_data;

	lattice_constant_fold_alu_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	rsp_t folded_q[$];
	int unsigned n_errors = 0;
	int unsigned send_idle_pct = 19;
	int unsigned recv_idle_pct = 47;
	int unsigned idle_cycles = 0;

	task automatic report(input string what, input rsp_t got, input rsp_t want);
		$display("MISMATCH %s: got kind %0d value %h, want kind %0d value %h",
			what, got.result_kind, got.result_value, want.result_kind, want.result_value);
		n_errors++;
	endtask

	function automatic logic [1:0] norm_kind(logic [1:0] k);
		return (k == KIND_BAD) ? KIND_VARYING : k;
	endfunction

	function automatic logic [63:0] trunc_ext(logic [63:0] v, logic [1:0] size, logic sx);
		logic [63:0] r;
		r = v;
		case (size)
			SIZE_1B: r = {{56{sx & v[7]}}, v[7:0]};
			SIZE_2B: r = {{48{sx & v[15]}}, v[15:0]};
			SIZE_4B: r = {{32{sx & v[31]}}, v[31:0]};
			default: r = v;
		endcase
		return r;
	endfunction

	// Folds one request into its lattice value.
	function automatic rsp_t fold_lattice(req_t q);
		logic [1:0] ak, bk, rk;
		logic [63:0] a, b, rv, t, ma, mb;
		logic [5:0] sh;
		logic ok, sgn, na, nb;
		ak = norm_kind(q.a_kind);
		bk = norm_kind(q.b_kind);
		a = q.a_value;
		b = q.b_value;
		sgn = q.operand_signed;
		sh = b[5:0] & ((q.dest_size == SIZE_8B) ? SHIFT_MASK_WIDE : SHIFT_MASK_NARROW);
		rk = KIND_VARYING;
		rv = '0;
		t = '0;
		ok = 1'b1;
		if (q.opcode == OP_MOV || q.opcode == OP_NEG || q.opcode == OP_NOT) begin
			rk = ak;
			t = (q.opcode == OP_MOV) ? a : (q.opcode == OP_NEG) ? -a : ~a;
			rv = trunc_ext(t, q.dest_size, q.dest_signed);
		end else if (q.opcode <= OP_GE) begin
			if (ak == KIND_VARYING || bk == KIND_VARYING) begin
				rk = KIND_VARYING;
			end else if (ak == KIND_UNKNOWN || bk == KIND_UNKNOWN) begin
				rk = KIND_UNKNOWN;
			end else begin
				case (q.opcode)
					OP_ADD: t = a + b;
					OP_SUB: t = a - b;
					OP_MUL: t = a * b;
					OP_DIV, OP_MOD: begin
						if (b == 0) begin
							ok = 1'b0;
						end else if (!sgn) begin
							t = (q.opcode == OP_DIV) ? a / b : a % b;
						end else if (a == SIGN_BIT && b == '1) begin
							ok = 1'b0;
						end else begin
							na = a[63];
							nb = b[63];
							ma = na ? -a : a;
							mb = nb ? -b : b;
							if (q.opcode == OP_DIV)
								t = (na != nb) ? -(ma / mb) : ma / mb;
							else
								t = na ? -(ma % mb) : ma % mb;
						end
					end
					OP_AND: t = a & b;
					OP_OR:  t = a | b;
					OP_XOR: t = a ^ b;
					OP_SHL: t = a << sh;
					OP_SHR: t = (sgn && a[63]) ? ~((~a) >> sh) : a >> sh;
					OP_EQ:  t = 64'(a == b);
					OP_NE:  t = 64'(a != b);
					OP_LT:  t = sgn ? 64'($signed(a) < $signed(b)) : 64'(a < b);
					OP_LE:  t = sgn ? 64'($signed(a) <= $signed(b)) : 64'(a <= b);
					OP_GT:  t = sgn ? 64'($signed(a) > $signed(b)) : 64'(a > b);
					default: t = sgn ? 64'($signed(a) >= $signed(b)) : 64'(a >= b);
				endcase
				if (ok) begin
					rk = KIND_CONST;
					rv = trunc_ext(t, q.dest_size, q.dest_signed);
				end
			end
		end else if (q.opcode == OP_MEET) begin
			if (ak == KIND_UNKNOWN) begin
				rk = bk;
				rv = b;
			end else if (bk == KIND_UNKNOWN) begin
				rk = ak;
				rv = a;
			end else if (ak == KIND_CONST && bk == KIND_CONST && a == b) begin
				rk = KIND_CONST;
				rv = a;
			end
		end
		if (rk != KIND_CONST)
			rv = '0;
		return '{result_kind: rk, result_value: rv};
	endfunction

	// Receiver: random stall, check in order at the rising edge.
	always @(negedge clk) begin
		if (arst_n)
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && out_valid && out_ready) begin
			if (folded_q.size() == 0) begin
				report("unexpected result", out_data, '0);
			end else begin
				want = folded_q.pop_front();
				if (out_data.result_kind !== want.result_kind)
					report("result_kind", out_data, want);
				else if (out_data.result_value !== want.result_value)
					report("result_value", out_data, want);
			end
		end
	end

	// Watchdog on cycles without any handshake.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("tb_lattice_constant_fold_alu_top NOT OK");
			$finish;
		end
	end

	// Sends one request; idles first at random, holds valid until taken.
	task automatic send_req(input req_t q);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= q;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		folded_q.push_back(fold_lattice(q));
		@(negedge clk);
	endtask

	function automatic logic [63:0] rand_value();
		case ($urandom_range(5))
			0: return 64'($urandom_range(15));
			1: return -64'($urandom_range(15));
			2: return SIGN_BIT;
			3: return {1'b0, {63{1'b1}}};
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic req_t rand_req();
		req_t q;
		q.opcode = ($urandom_range(19) == 0) ? 5'($urandom) : 5'($urandom_range(OP_MEET));
		// mostly constant operands so the arithmetic gets exercised
		q.a_kind = ($urandom_range(9) < 7) ? KIND_CONST : 2'($urandom);
		q.b_kind = ($urandom_range(9) < 7) ? KIND_CONST : 2'($urandom);
		q.a_value = rand_value();
		q.b_value = ($urandom_range(7) == 0) ? q.a_value : rand_value();
		q.operand_signed = 1'($urandom);
		q.dest_size = 2'($urandom);
		q.dest_signed = 1'($urandom);
		return q;
	endfunction

	typedef struct {
		req_t q;
		logic typed;
		rsp_t want;
	} vector_t;

	localparam logic [63:0] MinVal = SIGN_BIT;
	localparam logic [63:0] MaxVal = {1'b0, {63{1'b1}}};
	localparam logic [63:0] AllOnes = '1;

	vector_t vectors[] = '{
		'{'{OP_MOV, KIND_CONST, MaxVal, KIND_UNKNOWN, 0, 0, SIZE_8B, 1}, 1,
			'{KIND_CONST, MaxVal}},
		'{'{OP_MOV, KIND_CONST, MaxVal, KIND_UNKNOWN, 0, 0, SIZE_1B, 1}, 1,
			'{KIND_CONST, AllOnes}},
		'{'{OP_NEG, KIND_UNKNOWN, 5, KIND_UNKNOWN, 0, 0, SIZE_8B, 0}, 1,
			'{KIND_UNKNOWN, 0}},
		'{'{OP_NOT, KIND_BAD, 5, KIND_UNKNOWN, 0, 0, SIZE_8B, 0}, 1,
			'{KIND_VARYING, 0}},
		'{'{OP_NEG, KIND_CONST, MinVal, KIND_UNKNOWN, 0, 0, SIZE_8B, 1}, 1,
			'{KIND_CONST, MinVal}},
		'{'{OP_NOT, KIND_CONST, 0, KIND_UNKNOWN, 0, 0, SIZE_2B, 0}, 1,
			'{KIND_CONST, 64'hffff}},
		'{'{OP_ADD, KIND_CONST, MaxVal, KIND_CONST, 1, 0, SIZE_8B, 1}, 1,
			'{KIND_CONST, MinVal}},
		'{'{OP_SUB, KIND_VARYING, 1, KIND_UNKNOWN, 1, 0, SIZE_8B, 1}, 1,
			'{KIND_VARYING, 0}},
		'{'{OP_MUL, KIND_UNKNOWN, 1, KIND_CONST, 1, 0, SIZE_8B, 1}, 1,
			'{KIND_UNKNOWN, 0}},
		'{'{OP_DIV, KIND_CONST, 7, KIND_CONST, 0, 0, SIZE_8B, 1}, 1,
			'{KIND_VARYING, 0}},
		'{'{OP_MOD, KIND_CONST, MinVal, KIND_CONST, AllOnes, 1, SIZE_8B, 1}, 1,
			'{KIND_VARYING, 0}},
		'{'{OP_DIV, KIND_CONST, MinVal, KIND_CONST, AllOnes, 0, SIZE_8B, 1}, 0, '0},
		'{'{OP_DIV, KIND_CONST, -7, KIND_CONST, 2, 1, SIZE_4B, 1}, 0, '0},
		'{'{OP_MOD, KIND_CONST, -7, KIND_CONST, 2, 1, SIZE_8B, 0}, 0, '0},
		'{'{OP_AND, KIND_CONST, AllOnes, KIND_CONST, 64'h0f0f, 0, SIZE_1B, 0}, 0, '0},
		'{'{OP_OR, KIND_CONST, 1, KIND_CONST, 2, 0, SIZE_8B, 0}, 0, '0},
		'{'{OP_XOR, KIND_CONST, AllOnes, KIND_CONST, MinVal, 0, SIZE_8B, 0}, 0, '0},
		'{'{OP_SHL, KIND_CONST, 1, KIND_CONST, 63, 0, SIZE_8B, 0}, 0, '0},
		'{'{OP_SHL, KIND_CONST, 1, KIND_CONST, 63, 0, SIZE_4B, 0}, 0, '0},
		'{'{OP_SHR, KIND_CONST, MinVal, KIND_CONST, 63, 1, SIZE_8B, 1}, 0, '0},
		'{'{OP_SHR, KIND_CONST, MinVal, KIND_CONST, 63, 0, SIZE_8B, 1}, 0, '0},
		'{'{OP_LT, KIND_CONST, MinVal, KIND_CONST, 1, 1, SIZE_8B, 0}, 0, '0},
		'{'{OP_GE, KIND_CONST, MinVal, KIND_CONST, 1, 0, SIZE_8B, 0}, 0, '0},
		'{'{OP_MEET, KIND_CONST, 3, KIND_CONST, 4, 0, SIZE_1B, 0}, 1,
			'{KIND_VARYING, 0}},
		'{'{OP_MEET, KIND_UNKNOWN, 3, KIND_CONST, MaxVal, 0, SIZE_1B, 0}, 1,
			'{KIND_CONST, MaxVal}},
		'{'{5'd31, KIND_CONST, 3, KIND_CONST, 4, 0, SIZE_8B, 0}, 1,
			'{KIND_VARYING, 0}}
	};

	initial begin
		req_t q;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// Directed table; hand-typed results cross-check the predictor.
		foreach (vectors[i]) begin
			if (vectors[i].typed && fold_lattice(vectors[i].q) != vectors[i].want)
				report("directed row", fold_lattice(vectors[i].q), vectors[i].want);
			send_req(vectors[i].q);
		end
		in_valid <= 1'b0;
		// Drain fully before the random part.
		while (folded_q.size() != 0)
			@(negedge clk);

		for (int unsigned i = 0; i < RandomReqs; i++) begin
			if (i == RandomReqs / 3) begin
				send_idle_pct = 47;
				recv_idle_pct = 19;
			end else if (i == 2 * RandomReqs / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			q = rand_req();
			send_req(q);
		end
		in_valid <= 1'b0;

		while (folded_q.size() != 0)
			@(negedge clk);
		repeat (Latency + 10) @(negedge clk);
		if (n_errors == 0)
			$display("tb_lattice_constant_fold_alu_top OK");
		else
			$display("tb_lattice_constant_fold_alu_top NOT OK");
		$finish;
	end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/lcfa_pkg.sv
hw/rtl/lcfa_prep.sv
hw/rtl/lcfa_div_cell.sv
hw/rtl/lattice_constant_fold_alu_top.sv
test/tb_lattice_constant_fold_alu_top.sv
